// ===== hdl/eitp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eitp_pkg
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
package eitp_pkg;

    // Largest count the byte counter reaches before it saturates.
    localparam int DEFAULT_MAX_FRAME_BYTES = 65535;

    localparam logic [7:0]  ETH_HDR_BYTES    = 8'd14;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  IP_PROTO_TCP     = 8'd6;

    // Byte positions of the captured fields within the frame.
    localparam logic [15:0] POS_ETYPE_HI     = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO     = 16'd13;
    localparam logic [15:0] POS_IHL          = 16'd14;
    localparam logic [15:0] POS_TOTAL_HI     = 16'd16;
    localparam logic [15:0] POS_TOTAL_LO     = 16'd17;
    localparam logic [15:0] POS_PROTOCOL     = 16'd23;
    localparam logic [15:0] POS_TCP_BASE     = 16'd26;

    // Minimum captured lengths needed to reach a field.
    localparam logic [15:0] MIN_LEN_ETH      = 16'd14;
    localparam logic [15:0] MIN_LEN_PROTOCOL = 16'd24;

    typedef enum logic [1:0] {
        STATUS_TCP       = 2'd0,
        STATUS_NOT_IPV4  = 2'd1,
        STATUS_NOT_TCP   = 2'd2,
        STATUS_TOO_SHORT = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic        truncated;
        logic [5:0]  ip_header_bytes;
        logic [5:0]  tcp_header_bytes;
        logic [7:0]  payload_offset;
        logic [15:0] payload_bytes;
        logic [15:0] captured_length;
    } out_item_t;

    // Header fields of one complete frame, handed from capture to classify.
    typedef struct packed {
        logic [15:0] captured_length;
        logic [15:0] ethertype;
        logic [3:0]  ihl_words;
        logic [15:0] ip_total_len;
        logic [7:0]  ip_protocol;
        logic [3:0]  tcp_offset_words;
    } frame_snap_t;

endpackage
`default_nettype wire

// ===== hdl/eth_ipv4_tcp_header_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser_top
// Ethernet/IPv4/TCP header parser, one frame byte per transfer.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per transfer on the s_ channel and keeps up
// with one byte every clock cycle while s_ready is high, no gaps between
// frames. A frame ends with the last_byte transfer; it yields exactly one
// result transfer on the m_ channel via the snapshot and result registers.
// The rate is set by the byte counter and field capture registers, which
// update on every transfer. A snapshot register holds the finished frame's
// fields while the next frame is already being counted, and a result register
// holds the classified result; s_ready drops only when both are full and the
// result is not being taken. The byte counter saturates at MAX_FRAME_BYTES,
// after which further bytes are counted no more and no fields are captured.
// Reset is synchronous and active low on aresetn.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_header_parser_top #(
    parameter int MAX_FRAME_BYTES = eitp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  eitp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output eitp_pkg::out_item_t m_item
);

    // Handoff between the capture stage and the classify stage.
    logic                  snap_valid;
    logic                  snap_ready;
    eitp_pkg::frame_snap_t snap;

    // Counts bytes, captures header fields and snapshots them at end of frame.
    eitp_field_capture #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .snap_valid(snap_valid),
        .snap_ready(snap_ready),
        .snap      (snap)
    );

    // Classifies the snapshot and registers the result transfer.
    eitp_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .snap_valid(snap_valid),
        .snap_ready(snap_ready),
        .snap      (snap),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
`default_nettype wire

// ===== hdl/eitp_field_capture.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eitp_field_capture
// Byte counter and header field capture; latches a frame snapshot on the last byte.
// ----------------------------------------------------------------------------
module eitp_field_capture #(
    parameter int MAX_FRAME_BYTES = eitp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  eitp_pkg::in_item_t    s_item,
    output logic                  snap_valid,
    input  wire                   snap_ready,
    output eitp_pkg::frame_snap_t snap
);

    localparam logic [15:0] POS_LIMIT = 16'(MAX_FRAME_BYTES);

    logic [15:0] byte_pos_reg,  byte_pos_next;
    logic [15:0] etype_reg,     etype_next;
    logic [3:0]  ihl_reg,       ihl_next;
    logic [15:0] total_reg,     total_next;
    logic [7:0]  proto_reg,     proto_next;
    logic [3:0]  tcp_off_reg,   tcp_off_next;
    logic        snap_valid_reg;
    eitp_pkg::frame_snap_t snap_reg;

    logic        accept;
    logic        pos_open;
    logic [15:0] tcp_pos;

    assign s_ready    = !snap_valid_reg || snap_ready;
    assign accept     = s_valid && s_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // Field values with the current byte folded in.
    always_comb begin
        pos_open      = byte_pos_reg < POS_LIMIT;
        tcp_pos       = eitp_pkg::POS_TCP_BASE + {10'd0, ihl_reg, 2'b00};
        byte_pos_next = byte_pos_reg;
        etype_next    = etype_reg;
        ihl_next      = ihl_reg;
        total_next    = total_reg;
        proto_next    = proto_reg;
        tcp_off_next  = tcp_off_reg;
        if (pos_open) begin
            byte_pos_next = byte_pos_reg + 16'd1;
            if (byte_pos_reg == eitp_pkg::POS_ETYPE_HI) etype_next[15:8] = s_item.data_byte;
            if (byte_pos_reg == eitp_pkg::POS_ETYPE_LO) etype_next[7:0]  = s_item.data_byte;
            if (byte_pos_reg == eitp_pkg::POS_IHL)      ihl_next = s_item.data_byte[3:0];
            if (byte_pos_reg == eitp_pkg::POS_TOTAL_HI) total_next[15:8] = s_item.data_byte;
            if (byte_pos_reg == eitp_pkg::POS_TOTAL_LO) total_next[7:0]  = s_item.data_byte;
            if (byte_pos_reg == eitp_pkg::POS_PROTOCOL) proto_next = s_item.data_byte;
            if (byte_pos_reg == tcp_pos)                tcp_off_next = s_item.data_byte[7:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg   <= '0;
            etype_reg      <= '0;
            ihl_reg        <= '0;
            total_reg      <= '0;
            proto_reg      <= '0;
            tcp_off_reg    <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            if (accept && s_item.last_byte) begin
                byte_pos_reg   <= '0;
                etype_reg      <= '0;
                ihl_reg        <= '0;
                total_reg      <= '0;
                proto_reg      <= '0;
                tcp_off_reg    <= '0;
                snap_valid_reg <= 1'b1;
            end else begin
                if (accept) begin
                    byte_pos_reg <= byte_pos_next;
                    etype_reg    <= etype_next;
                    ihl_reg      <= ihl_next;
                    total_reg    <= total_next;
                    proto_reg    <= proto_next;
                    tcp_off_reg  <= tcp_off_next;
                end
                if (snap_ready) begin
                    snap_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_item.last_byte) begin
            snap_reg.captured_length  <= byte_pos_next;
            snap_reg.ethertype        <= etype_next;
            snap_reg.ihl_words        <= ihl_next;
            snap_reg.ip_total_len     <= total_next;
            snap_reg.ip_protocol      <= proto_next;
            snap_reg.tcp_offset_words <= tcp_off_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The running state starts over after the last byte of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.last_byte |=> byte_pos_reg == 16'd0 && ihl_reg == 4'd0)
        else $error("byte counter not cleared after end of frame");

    // The counter never passes its saturation limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_pos_reg <= POS_LIMIT)
        else $error("byte counter beyond limit");

    // A middle byte below the limit advances the counter by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_item.last_byte && pos_open
        |=> byte_pos_reg == $past(byte_pos_reg) + 16'd1)
        else $error("byte counter did not advance");
`endif

endmodule
`default_nettype wire

// ===== hdl/eitp_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eitp_classify
// Classifies a captured frame and computes header and payload lengths.
// ----------------------------------------------------------------------------
module eitp_classify (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   snap_valid,
    output logic                  snap_ready,
    input  eitp_pkg::frame_snap_t snap,
    output logic                  m_valid,
    input  wire                   m_ready,
    output eitp_pkg::out_item_t   m_item
);

    logic                m_valid_reg;
    eitp_pkg::out_item_t m_item_reg;
    eitp_pkg::out_item_t m_item_next;

    logic [5:0]  iph;
    logic [5:0]  tcph;
    logic [6:0]  hdr_sum;
    logic [7:0]  poff;
    logic [15:0] tcp_end;
    logic [16:0] total_plus_eth;
    logic        trunc;
    logic [15:0] plen;

    assign snap_ready = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_item     = m_item_reg;

    always_comb begin
        iph            = {snap.ihl_words, 2'b00};
        tcph           = {snap.tcp_offset_words, 2'b00};
        hdr_sum        = {1'b0, iph} + {1'b0, tcph};
        poff           = eitp_pkg::ETH_HDR_BYTES + {1'b0, hdr_sum};
        tcp_end        = eitp_pkg::POS_TCP_BASE + {10'd0, iph};
        total_plus_eth = {1'b0, snap.ip_total_len} + {9'd0, eitp_pkg::ETH_HDR_BYTES};
        trunc          = {1'b0, snap.captured_length} < total_plus_eth;
        if (trunc) begin
            plen = (snap.captured_length > {8'd0, poff})
                 ? snap.captured_length - {8'd0, poff} : 16'd0;
        end else begin
            plen = (snap.ip_total_len > {9'd0, hdr_sum})
                 ? snap.ip_total_len - {9'd0, hdr_sum} : 16'd0;
        end

        m_item_next                 = '0;
        m_item_next.captured_length = snap.captured_length;
        priority if (snap.captured_length < eitp_pkg::MIN_LEN_ETH) begin
            m_item_next.status = eitp_pkg::STATUS_TOO_SHORT;
        end else if (snap.ethertype != eitp_pkg::ETHERTYPE_IPV4) begin
            m_item_next.status = eitp_pkg::STATUS_NOT_IPV4;
        end else if (snap.captured_length < eitp_pkg::MIN_LEN_PROTOCOL) begin
            m_item_next.status = eitp_pkg::STATUS_TOO_SHORT;
        end else if (snap.ip_protocol != eitp_pkg::IP_PROTO_TCP) begin
            m_item_next.status = eitp_pkg::STATUS_NOT_TCP;
        end else if (snap.captured_length <= tcp_end) begin
            m_item_next.status = eitp_pkg::STATUS_TOO_SHORT;
        end else begin
            m_item_next.status           = eitp_pkg::STATUS_TCP;
            m_item_next.truncated        = trunc;
            m_item_next.ip_header_bytes  = iph;
            m_item_next.tcp_header_bytes = tcph;
            m_item_next.payload_offset   = poff;
            m_item_next.payload_bytes    = plen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_valid && snap_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            m_item_reg <= m_item_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Frames that are not TCP carry only their status and captured length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != eitp_pkg::STATUS_TCP
        |-> m_item.truncated == 1'b0 && m_item.payload_offset == 8'd0
            && m_item.payload_bytes == 16'd0)
        else $error("non-TCP result carries header fields");

    // A TCP result always points past the Ethernet header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == eitp_pkg::STATUS_TCP
        |-> m_item.payload_offset >= eitp_pkg::ETH_HDR_BYTES)
        else $error("payload offset inside Ethernet header");

    // A frame snapshot taken in turns into a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid && snap_ready |=> m_valid)
        else $error("result lost after snapshot transfer");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/eitp_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eitp_frame_checker
// Watches both channels of the header parser and checks every frame summary.
// ----------------------------------------------------------------------------
// Every byte transfer on the input side is run through a behavioral copy of
// the parser. The final byte of a frame queues the summary the parser should
// produce, and every result transfer is compared field by field with the
// oldest queued summary.
// ----------------------------------------------------------------------------
module eitp_frame_checker #(
    parameter int MAX_FRAME_BYTES = eitp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  eitp_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  eitp_pkg::out_item_t m_item,
    output int                  mismatch_count,
    output int                  summaries_pending
);

    logic [15:0] seen_bytes;
    logic [15:0] ethertype;
    logic [3:0]  ihl_words;
    logic [15:0] ip_total_len;
    logic [7:0]  ip_protocol;
    logic [3:0]  tcp_offset_words;

    eitp_pkg::out_item_t frame_summaries[$];
    int                  mismatches = 0;
    int                  summaries_checked = 0;

    task automatic clear_frame();
        seen_bytes       = '0;
        ethertype        = '0;
        ihl_words        = '0;
        ip_total_len     = '0;
        ip_protocol      = '0;
        tcp_offset_words = '0;
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: frame summary %0d: %s", $time, summaries_checked, what);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic eitp_pkg::out_item_t summarize_frame();
        eitp_pkg::out_item_t sum;
        int                  caplen;
        int                  iph;
        int                  tcph;
        int                  poff;
        int                  plen;
        sum = '0;
        sum.status = eitp_pkg::STATUS_TCP;
        sum.captured_length = seen_bytes;
        caplen = seen_bytes;
        iph  = 4 * ihl_words;
        tcph = 4 * tcp_offset_words;
        if (caplen < eitp_pkg::MIN_LEN_ETH) begin
            sum.status = eitp_pkg::STATUS_TOO_SHORT;
        end else if (ethertype != eitp_pkg::ETHERTYPE_IPV4) begin
            sum.status = eitp_pkg::STATUS_NOT_IPV4;
        end else if (caplen < eitp_pkg::MIN_LEN_PROTOCOL) begin
            sum.status = eitp_pkg::STATUS_TOO_SHORT;
        end else if (ip_protocol != eitp_pkg::IP_PROTO_TCP) begin
            sum.status = eitp_pkg::STATUS_NOT_TCP;
        end else if (caplen <= eitp_pkg::POS_TCP_BASE + iph) begin
            // The byte holding the TCP data offset never arrived.
            sum.status = eitp_pkg::STATUS_TOO_SHORT;
        end else begin
            poff = eitp_pkg::ETH_HDR_BYTES + iph + tcph;
            if (caplen < ip_total_len + eitp_pkg::ETH_HDR_BYTES) begin
                sum.truncated = 1'b1;
                plen = (caplen > poff) ? caplen - poff : 0;
            end else begin
                plen = (ip_total_len > iph + tcph) ? ip_total_len - (iph + tcph) : 0;
            end
            sum.ip_header_bytes  = 6'(iph);
            sum.tcp_header_bytes = 6'(tcph);
            sum.payload_offset   = 8'(poff);
            sum.payload_bytes    = 16'(plen);
        end
        return sum;
    endfunction

    task automatic count_byte(input eitp_pkg::in_item_t item);
        int pos;
        pos = seen_bytes;
        // Once the counter has saturated nothing more is captured.
        if (pos < MAX_FRAME_BYTES) begin
            if (pos == eitp_pkg::POS_ETYPE_HI) ethertype[15:8]    = item.data_byte;
            if (pos == eitp_pkg::POS_ETYPE_LO) ethertype[7:0]     = item.data_byte;
            if (pos == eitp_pkg::POS_IHL)      ihl_words          = item.data_byte[3:0];
            if (pos == eitp_pkg::POS_TOTAL_HI) ip_total_len[15:8] = item.data_byte;
            if (pos == eitp_pkg::POS_TOTAL_LO) ip_total_len[7:0]  = item.data_byte;
            if (pos == eitp_pkg::POS_PROTOCOL) ip_protocol        = item.data_byte;
            if (pos == eitp_pkg::POS_TCP_BASE + 4 * ihl_words)
                tcp_offset_words = item.data_byte[7:4];
            seen_bytes = seen_bytes + 16'd1;
        end
        if (item.last_byte) begin
            frame_summaries.push_back(summarize_frame());
            clear_frame();
        end
    endtask

    task automatic check_summary(input eitp_pkg::out_item_t got);
        eitp_pkg::out_item_t want;
        if (frame_summaries.size() == 0) begin
            report_mismatch("result transfer with no frame outstanding");
        end else begin
            want = frame_summaries.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("truncated", got.truncated, want.truncated);
            compare_field("ip_header_bytes", got.ip_header_bytes, want.ip_header_bytes);
            compare_field("tcp_header_bytes", got.tcp_header_bytes, want.tcp_header_bytes);
            compare_field("payload_offset", got.payload_offset, want.payload_offset);
            compare_field("payload_bytes", got.payload_bytes, want.payload_bytes);
            compare_field("captured_length", got.captured_length, want.captured_length);
            summaries_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame();
            frame_summaries.delete();
        end else begin
            if (s_valid && s_ready) count_byte(s_item);
            if (m_valid && m_ready) check_summary(m_item);
        end
        summaries_pending <= frame_summaries.size();
        mismatch_count    <= mismatches;
    end

endmodule

// ===== tb/sv/eth_ipv4_tcp_header_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser_top_tb
// Frame-level stimulus and verdict for the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
// Frames are streamed into the parser one byte per transfer. A directed set
// covers the short-frame cutoffs, the classification paths, clamped payload
// lengths and odd header lengths. A pressure phase then stalls the result
// side for a long stretch, and a random phase follows with mostly
// well-formed TCP frames and some cut, foreign and garbage frames.
// A separate checker predicts and compares; this module drives and judges.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_header_parser_top_tb;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_BYTES   = 750;
    localparam int RANDOM_FRAMES  = 6;

    // Receiver behavior, switched at random intervals.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_COMB
    } sink_mode_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    eitp_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    eitp_pkg::out_item_t m_item;

    int mismatch_count;
    int summaries_pending;

    // Bytes of the frame currently being sent.
    logic [7:0] frame_buf[$];

    int burst_left   = 0;
    int bytes_sent   = 0;
    int quiet_cycles = 0;
    bit gapless      = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    eth_ipv4_tcp_header_parser_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    eitp_frame_checker summary_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_item            (s_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item            (m_item),
        .mismatch_count    (mismatch_count),
        .summaries_pending (summaries_pending)
    );

    // Offer one byte and hold it until the parser takes it. The sender works in
    // bursts of random length; before each new burst valid drops for a random
    // gap. Some bursts are long, so there are stretches without any gaps.
    // In gapless mode bytes are offered back to back.
    task automatic offer_byte(input logic [7:0] data, input logic last);
        eitp_pkg::in_item_t item;
        int                 gap;
        if (burst_left == 0 && !gapless) begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.data_byte = data;
        item.last_byte = last;
        s_valid <= 1'b1;
        s_item  <= item;
        // The handshake is judged on the values present just before the edge.
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) burst_left--;
        bytes_sent++;
    endtask

    // Write a header byte only where the frame is long enough to hold it.
    function automatic void place_byte(input int idx, input logic [7:0] val);
        if (idx < frame_buf.size()) frame_buf[idx] = val;
    endfunction

    // Build a frame of random bytes with the parsed header fields laid over
    // it, then stream it out with the last flag on its final byte.
    task automatic send_frame(input int len, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [15:0] ip_len,
                              input logic [7:0] proto, input logic [3:0] tcp_off);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
        place_byte(eitp_pkg::POS_ETYPE_HI, etype[15:8]);
        place_byte(eitp_pkg::POS_ETYPE_LO, etype[7:0]);
        place_byte(eitp_pkg::POS_IHL, {4'($urandom), ihl});
        place_byte(eitp_pkg::POS_TOTAL_HI, ip_len[15:8]);
        place_byte(eitp_pkg::POS_TOTAL_LO, ip_len[7:0]);
        place_byte(eitp_pkg::POS_PROTOCOL, proto);
        place_byte(eitp_pkg::POS_TCP_BASE + 4 * ihl, {tcp_off, 4'($urandom)});
        foreach (frame_buf[i])
            offer_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Random frame: mostly TCP over IPv4 with random header lengths and an IP
    // total length that matches, undershoots (padding) or overshoots
    // (truncation). The rest are frames cut inside the headers, foreign
    // ethertypes, other IP protocols and plain garbage.
    task automatic send_random_frame();
        int          kind;
        int          len;
        int          tcp_pos;
        int          hdr_end;
        logic [3:0]  ihl;
        logic [3:0]  tcp_off;
        logic [15:0] etype;
        logic [15:0] ip_len;
        logic [7:0]  proto;
        kind    = $urandom_range(0, 99);
        ihl     = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(5, 15));
        tcp_off = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(5, 15));
        etype   = eitp_pkg::ETHERTYPE_IPV4;
        proto   = eitp_pkg::IP_PROTO_TCP;
        tcp_pos = eitp_pkg::POS_TCP_BASE + 4 * ihl;
        hdr_end = eitp_pkg::ETH_HDR_BYTES + 4 * ihl + 4 * tcp_off;
        len     = ((hdr_end > tcp_pos) ? hdr_end : tcp_pos + 1) + $urandom_range(0, 40);
        case ($urandom_range(0, 3))
            0:       ip_len = 16'(len - eitp_pkg::ETH_HDR_BYTES);
            1:       ip_len = 16'($urandom_range(0, len - eitp_pkg::ETH_HDR_BYTES));
            2:       ip_len = 16'(len - eitp_pkg::ETH_HDR_BYTES + $urandom_range(1, 200));
            default: ip_len = 16'($urandom);
        endcase
        if (kind >= 70 && kind < 82) begin
            // Frame that ends somewhere inside the headers.
            len = $urandom_range(1, tcp_pos + 1);
        end else if (kind >= 82 && kind < 90) begin
            etype = 16'($urandom);
        end else if (kind >= 90 && kind < 96) begin
            proto = 8'($urandom);
        end else if (kind >= 96) begin
            etype   = 16'($urandom);
            proto   = 8'($urandom);
            ip_len  = 16'($urandom);
            ihl     = 4'($urandom);
            tcp_off = 4'($urandom);
            len     = $urandom_range(1, 120);
        end
        send_frame(len, etype, ihl, ip_len, proto, tcp_off);
    endtask

    // Result side. It switches between always ready, coin flips, mostly
    // stalled and a regular on/off comb. When the stimulus asks for it, it
    // holds m_ready low for a long stretch once, so the parser's snapshot and
    // result registers fill and s_ready drops while the sender keeps offering.
    initial begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        mode      = SINK_OPEN;
        mode_left = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= mode_left[2];
                endcase
                @(posedge aclk);
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("eth_ipv4_tcp_header_parser_top_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int first_random_byte;
        int random_frames;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames. The short ones walk the status cutoffs: a single
        // byte, one byte short of the ethertype, ethertype only (foreign and
        // IPv4), one byte short of the protocol, and a frame that stops just
        // before the TCP data offset byte.
        send_frame(1, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(13, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(14, 16'hFFFF, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(14, 16'h0000, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(14, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(23, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(24, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, 8'hFF, 4'd5);
        send_frame(24, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(46, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        // Just long enough for TCP, with a total length below the headers, so
        // the payload length would go negative without truncation.
        send_frame(47, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd33, eitp_pkg::IP_PROTO_TCP, 4'd5);
        // Exact lengths: no payload, then a 20-byte payload.
        send_frame(54, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40, eitp_pkg::IP_PROTO_TCP, 4'd5);
        send_frame(74, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd60, eitp_pkg::IP_PROTO_TCP, 4'd5);
        // Largest headers with the largest total length: truncated, first with
        // the capture ending before the payload offset, then past it.
        send_frame(100, eitp_pkg::ETHERTYPE_IPV4, 4'd15, 16'hFFFF,
                   eitp_pkg::IP_PROTO_TCP, 4'd15);
        send_frame(150, eitp_pkg::ETHERTYPE_IPV4, 4'd15, 16'hFFFF,
                   eitp_pkg::IP_PROTO_TCP, 4'd15);
        // Header length fields below the legal minimum are taken as they are.
        send_frame(60, eitp_pkg::ETHERTYPE_IPV4, 4'd0, 16'd46, eitp_pkg::IP_PROTO_TCP, 4'd0);
        send_frame(40, eitp_pkg::ETHERTYPE_IPV4, 4'd4, 16'd0, eitp_pkg::IP_PROTO_TCP, 4'd3);
        // Frame whose total length plus the Ethernet header equals the capture.
        send_frame(80, eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd66, eitp_pkg::IP_PROTO_TCP, 4'd8);

        // Back-pressure: the receiver holds off while frames stream in with
        // no gaps, so the parser fills and must stall its input.
        hold_request = 1'b1;
        gapless      = 1'b1;
        repeat (12)
            send_frame($urandom_range(1, 60), eitp_pkg::ETHERTYPE_IPV4, 4'd5, 16'd40,
                       eitp_pkg::IP_PROTO_TCP, 4'd5);
        gapless = 1'b0;

        // Random frames until enough bytes and frames have gone through.
        first_random_byte = bytes_sent;
        random_frames     = 0;
        while (bytes_sent - first_random_byte < RANDOM_BYTES
               || random_frames < RANDOM_FRAMES) begin
            send_random_frame();
            random_frames++;
        end
        s_valid <= 1'b0;

        // Let the outstanding summaries drain, then give stray results a
        // chance to show up before the verdict.
        do @(posedge aclk); while (summaries_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && summaries_pending == 0) begin
            $display("eth_ipv4_tcp_header_parser_top_tb passed");
        end else begin
            $display("eth_ipv4_tcp_header_parser_top_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/eitp_pkg.sv
hdl/eitp_field_capture.sv
hdl/eitp_classify.sv
hdl/eth_ipv4_tcp_header_parser_top.sv
tb/sv/eitp_frame_checker.sv
tb/sv/eth_ipv4_tcp_header_parser_top_tb.sv
